// File: rtl/gdd_pkg.sv
// constants, types and calendar tables for the gregorian day difference block
package gdd_pkg;

  // fixed field widths
  localparam int DAY_W = 5;
  localparam int MON_W = 4;
  localparam int DOY_W = 9;
  localparam int CNT_W = 24;

  // calendar constants
  localparam logic [MON_W-1:0] MON_JAN = 4'd1;
  localparam logic [MON_W-1:0] MON_FEB = 4'd2;
  localparam logic [MON_W-1:0] MON_DEC = 4'd12;
  localparam logic [DAY_W-1:0] DAY_FIRST = 5'd1;
  localparam logic [8:0] DAYS_PER_YEAR = 9'd365;
  localparam logic [6:0] CENTURY = 7'd100;

  // floor(x / 25) as (x * DIV25_MUL) >> DIV25_SHIFT, exact for x below 43690
  localparam int DIV25_MUL_W = 15;
  localparam logic [DIV25_MUL_W-1:0] DIV25_MUL = 15'd20972;
  localparam int DIV25_SHIFT = 19;

  typedef logic [DAY_W-1:0] day_t;
  typedef logic [MON_W-1:0] mon_t;
  typedef logic [DOY_W-1:0] doy_t;
  typedef logic [CNT_W-1:0] cnt_t;

  // length of a month in a common year, zero for codes that are no month
  function automatic day_t month_len(input mon_t m);
    day_t len;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

  // days of a common year before the first of the month
  function automatic doy_t days_before(input mon_t m);
    doy_t n;
    unique case (m)
      4'd2:    n = 9'd31;
      4'd3:    n = 9'd59;
      4'd4:    n = 9'd90;
      4'd5:    n = 9'd120;
      4'd6:    n = 9'd151;
      4'd7:    n = 9'd181;
      4'd8:    n = 9'd212;
      4'd9:    n = 9'd243;
      4'd10:   n = 9'd273;
      4'd11:   n = 9'd304;
      4'd12:   n = 9'd334;
      default: n = 9'd0;
    endcase
    return n;
  endfunction

endpackage

// File: rtl/gregorian_day_difference.sv
// gregorian day difference: date validity, ordering and day count pipeline
//
// Takes a pair of Gregorian dates (first and second) per transaction and returns
// whether each date is valid, whether the first is on or after the second, and the
// number of days from the second to the first (zero when either date is invalid or the
// first is earlier). One transaction is accepted every cycle unless in_stall is high;
// the result passes four register stages: compare, divide-by-25 multiply, leap and
// day-of-year evaluation, and the final sum. Stages holding no transaction are filled
// while the output is stalled, so input is only stalled once every stage holds a result.
module gregorian_day_difference #(
  parameter int YEAR_WIDTH = 15
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [4:0]               in_day_a,
  input  logic [3:0]               in_month_a,
  input  logic [YEAR_WIDTH-1:0]    in_year_a,
  input  logic [4:0]               in_day_b,
  input  logic [3:0]               in_month_b,
  input  logic [YEAR_WIDTH-1:0]    in_year_b,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [23:0]              out_day_count,
  output logic                     out_first_not_earlier,
  output logic                     out_first_valid,
  output logic                     out_second_valid
);

  localparam int Q4_W   = YEAR_WIDTH - 2;
  localparam int PROD_W = Q4_W + gdd_pkg::DIV25_MUL_W;
  localparam int Q100_W = PROD_W - gdd_pkg::DIV25_SHIFT;

  typedef logic [YEAR_WIDTH-1:0] year_t;
  typedef logic [Q4_W-1:0]       q4_t;
  typedef logic [PROD_W-1:0]     prod_t;
  typedef logic [Q100_W-1:0]     q100_t;

  // per-stage enables: a stage loads when it is empty or the next one moves on
  logic en1, en2, en3, en4;
  logic v1_r, v2_r, v3_r, v4_r;

  assign en4 = !v4_r || !out_stall;
  assign en3 = !v3_r || en4;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;
  assign in_stall = !en1;

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
    end
  end

  // stage 1: ordering compare, quarter of the year and of the year before
  gdd_pkg::day_t day_in [2];
  gdd_pkg::mon_t mon_in [2];
  year_t         yr_in  [2];
  logic          ge_nxt;

  assign day_in[0] = in_day_a;
  assign day_in[1] = in_day_b;
  assign mon_in[0] = in_month_a;
  assign mon_in[1] = in_month_b;
  assign yr_in[0]  = in_year_a;
  assign yr_in[1]  = in_year_b;

  assign ge_nxt = (in_year_a > in_year_b) ||
                  ((in_year_a == in_year_b) &&
                   ((in_month_a > in_month_b) ||
                    ((in_month_a == in_month_b) && (in_day_a >= in_day_b))));

  gdd_pkg::day_t day1_r [2];
  gdd_pkg::mon_t mon1_r [2];
  year_t         yr1_r  [2];
  q4_t           q4y1_r [2];
  q4_t           q4m1_r [2];
  logic          ge1_r;

  always_ff @(posedge clk) begin
    if (en1) begin
      for (int i = 0; i < 2; i++) begin
        day1_r[i] <= day_in[i];
        mon1_r[i] <= mon_in[i];
        yr1_r[i]  <= yr_in[i];
        q4y1_r[i] <= yr_in[i][YEAR_WIDTH-1:2];
        q4m1_r[i] <= q4_t'(year_t'(yr_in[i] - year_t'(1)) >> 2);
      end
      ge1_r <= ge_nxt;
    end
  end

  // stage 2: reciprocal multiply for the division by 25
  gdd_pkg::day_t day2_r [2];
  gdd_pkg::mon_t mon2_r [2];
  year_t         yr2_r  [2];
  q4_t           q4m2_r [2];
  prod_t         py2_r  [2];
  prod_t         pm2_r  [2];
  logic          ge2_r;

  always_ff @(posedge clk) begin
    if (en2) begin
      for (int i = 0; i < 2; i++) begin
        day2_r[i] <= day1_r[i];
        mon2_r[i] <= mon1_r[i];
        yr2_r[i]  <= yr1_r[i];
        q4m2_r[i] <= q4m1_r[i];
        py2_r[i]  <= prod_t'(q4y1_r[i]) * prod_t'(gdd_pkg::DIV25_MUL);
        pm2_r[i]  <= prod_t'(q4m1_r[i]) * prod_t'(gdd_pkg::DIV25_MUL);
      end
      ge2_r <= ge1_r;
    end
  end

  // stage 3: leap year, validity, day of year and leap years before the year
  q100_t         q100y   [2];
  q100_t         q100m   [2];
  logic          leap    [2];
  gdd_pkg::day_t len     [2];
  logic          dvalid  [2];
  gdd_pkg::doy_t doy     [2];
  q4_t           leaps   [2];

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      q100y[i] = py2_r[i][PROD_W-1:gdd_pkg::DIV25_SHIFT];
      q100m[i] = pm2_r[i][PROD_W-1:gdd_pkg::DIV25_SHIFT];
      leap[i]  = (yr2_r[i][1:0] == 2'b00) &&
                 ((yr2_r[i] != year_t'(year_t'(q100y[i]) *
                                       year_t'(gdd_pkg::CENTURY))) ||
                  (q100y[i][1:0] == 2'b00));
      len[i]   = gdd_pkg::month_len(mon2_r[i]) +
                 gdd_pkg::day_t'((mon2_r[i] == gdd_pkg::MON_FEB) && leap[i]);
      dvalid[i] = (yr2_r[i] != year_t'(0)) &&
                  (mon2_r[i] >= gdd_pkg::MON_JAN) && (mon2_r[i] <= gdd_pkg::MON_DEC) &&
                  (day2_r[i] >= gdd_pkg::DAY_FIRST) && (day2_r[i] <= len[i]);
      doy[i]   = gdd_pkg::days_before(mon2_r[i]) + gdd_pkg::doy_t'(day2_r[i]) +
                 gdd_pkg::doy_t'((mon2_r[i] > gdd_pkg::MON_FEB) && leap[i]);
      leaps[i] = q4m2_r[i] - q4_t'(q100m[i]) + q4_t'(q100m[i] >> 2);
    end
  end

  year_t         yr3_r    [2];
  gdd_pkg::doy_t doy3_r   [2];
  q4_t           leaps3_r [2];
  logic          val3_r   [2];
  logic          ge3_r;

  always_ff @(posedge clk) begin
    if (en3) begin
      for (int i = 0; i < 2; i++) begin
        yr3_r[i]    <= yr2_r[i];
        doy3_r[i]   <= doy[i];
        leaps3_r[i] <= leaps[i];
        val3_r[i]   <= dvalid[i];
      end
      ge3_r <= ge2_r;
    end
  end

  // stage 4: whole years, leap-day and day-of-year differences, modulo the count width
  gdd_pkg::cnt_t count_nxt;

  always_comb begin
    count_nxt = gdd_pkg::cnt_t'(year_t'(yr3_r[0] - yr3_r[1])) *
                gdd_pkg::cnt_t'(gdd_pkg::DAYS_PER_YEAR) +
                gdd_pkg::cnt_t'(leaps3_r[0]) - gdd_pkg::cnt_t'(leaps3_r[1]) +
                gdd_pkg::cnt_t'(doy3_r[0]) - gdd_pkg::cnt_t'(doy3_r[1]);
    if (!(val3_r[0] && val3_r[1] && ge3_r)) begin
      count_nxt = '0;
    end
  end

  gdd_pkg::cnt_t count4_r;
  logic          ge4_r;
  logic          va4_r;
  logic          vb4_r;

  always_ff @(posedge clk) begin
    if (en4) begin
      count4_r <= count_nxt;
      ge4_r    <= ge3_r;
      va4_r    <= val3_r[0];
      vb4_r    <= val3_r[1];
    end
  end

  // result transaction
  assign out_valid             = v4_r;
  assign out_day_count         = count4_r;
  assign out_first_not_earlier = ge4_r;
  assign out_first_valid       = va4_r;
  assign out_second_valid      = vb4_r;

endmodule
